[rtl/dai_pkg.sv]
// ============================================================================
// dai_pkg: shared types and constants for the arm inverse kinematics unit
// Field widths, cell data records, CORDIC table and pipeline depths.
// ============================================================================
package dai_pkg;

    localparam int ARM_COUNT = 3;
    localparam int ARM_IDX_W = 2;

    localparam int POS_W   = 24;
    localparam int LEN_W   = 20;
    localparam int SPR_W   = 24;
    localparam int STEP_W  = 21;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 24;

    localparam int TRIG_W  = 18;
    localparam int SUM_W   = POS_W + TRIG_W;
    localparam int FRAC_Q16 = 16;
    localparam int OFF_W   = LEN_W + 1;
    localparam int EX_W    = 26;
    localparam int LSQ_W   = 2 * LEN_W + 2;
    localparam int NUM_W   = 54;

    // square root cell, 2 radicand bits per step
    localparam int SQ_W      = 52;
    localparam int SQ_ROOT_W = SQ_W / 2;
    localparam int SQ_REM_W  = SQ_ROOT_W + 2;
    localparam int D_STEPS   = SQ_ROOT_W;
    localparam int S_STEPS   = 17;
    localparam int SQ_PAD    = SQ_W - 2 * S_STEPS;
    localparam int SRAD_W    = 2 * S_STEPS - 1;

    // restoring divider cell, one quotient bit per step
    localparam int DV_W     = 48;
    localparam int DV_Q_W   = 17;
    localparam int DV_STEPS = DV_Q_W;
    localparam int C_W      = DV_Q_W + 1;

    // CORDIC vectoring cell
    localparam int CR_W     = 28;
    localparam int CR_Z_W   = 20;
    localparam int CR_STEPS = 16;
    localparam int CR_I_W   = 4;
    localparam int CR_PRE   = 8;
    localparam int ATAN_W   = 16;

    localparam int ANG_W      = 18;
    localparam int STEP_SHIFT = 28;

    // stages from the divider input of the acos unit to its angle register
    localparam int ACOS_LAT = DV_STEPS + 3 + S_STEPS + 1 + CR_STEPS + 1;
    // reach flag delay: divider input register, acos, difference, product, steps
    localparam int FAIL_DLY = ACOS_LAT + 4;
    localparam int ARM_LAT  = 4 + D_STEPS + 1 + FAIL_DLY;

    localparam logic signed [SUM_W-1:0]  ROUND_Q16   = SUM_W'(32768);
    localparam logic [SRAD_W-1:0]        ONE_SQ_Q32  = SRAD_W'(64'h1_0000_0000);
    localparam logic signed [CR_Z_W-1:0] HALF_PI_Q16 = CR_Z_W'(102944);
    localparam logic signed [CR_Z_W-1:0] PI_Q16      = CR_Z_W'(205887);

    localparam logic signed [TRIG_W-1:0] ARM_COS [ARM_COUNT] = '{
        TRIG_W'(65536), -TRIG_W'(32768), -TRIG_W'(32768)
    };
    localparam logic signed [TRIG_W-1:0] ARM_SIN [ARM_COUNT] = '{
        TRIG_W'(0), TRIG_W'(56756), -TRIG_W'(56756)
    };

    localparam logic [ATAN_W-1:0] ATAN_TAB [CR_STEPS] = '{
        16'd51472, 16'd30386, 16'd16055, 16'd8150, 16'd4091, 16'd2047,
        16'd1024, 16'd512, 16'd256, 16'd128, 16'd64, 16'd32, 16'd16,
        16'd8, 16'd4, 16'd2
    };

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_BASE_RADIUS      = 3'd0,
        REG_EFFECTOR_RADIUS  = 3'd1,
        REG_UPPER_ARM_LENGTH = 3'd2,
        REG_LOWER_ARM_LENGTH = 3'd3,
        REG_STEPS_PER_RADIAN = 3'd4
    } reg_index_t;

    typedef struct packed {
        logic signed [OFF_W-1:0] off;
        logic [LEN_W-1:0]        l1;
        logic signed [LSQ_W-1:0] lsqd;
        logic [SPR_W-1:0]        spr;
    } dai_cfg_t;

    typedef struct packed {
        logic [SQ_W-1:0]      rad;
        logic [SQ_REM_W-1:0]  rem;
        logic [SQ_ROOT_W-1:0] root;
    } sq_t;

    typedef struct packed {
        logic [DV_W-1:0]   rem;
        logic [DV_W-1:0]   den;
        logic [DV_Q_W-1:0] q;
    } dv_t;

    typedef struct packed {
        logic signed [CR_W-1:0]   x;
        logic signed [CR_W-1:0]   y;
        logic signed [CR_Z_W-1:0] z;
    } cr_t;

endpackage

[rtl/dai_sqrt_cell.sv]
// ============================================================================
// dai_sqrt_cell: one step of a digit-by-digit integer square root
// Consumes two radicand bits and produces one root bit per cycle.
// ============================================================================
module dai_sqrt_cell (
    input  logic          clk,
    input  dai_pkg::sq_t  din,
    output dai_pkg::sq_t  dout
);

    dai_pkg::sq_t dout_reg;
    dai_pkg::sq_t dout_next;
    logic [dai_pkg::SQ_REM_W-1:0] rem_sh;
    logic [dai_pkg::SQ_REM_W-1:0] trial;

    always_comb
    begin
        rem_sh = {din.rem[dai_pkg::SQ_REM_W-3:0], din.rad[dai_pkg::SQ_W-1 -: 2]};
        trial  = {din.root, 2'b01};
        dout_next.rad = {din.rad[dai_pkg::SQ_W-3:0], 2'b00};
        if (rem_sh >= trial)
        begin
            dout_next.rem  = rem_sh - trial;
            dout_next.root = {din.root[dai_pkg::SQ_ROOT_W-2:0], 1'b1};
        end
        else
        begin
            dout_next.rem  = rem_sh;
            dout_next.root = {din.root[dai_pkg::SQ_ROOT_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[rtl/dai_div_cell.sv]
// ============================================================================
// dai_div_cell: one step of a restoring divider
// Compare and subtract the divisor, shift in one quotient bit.
// ============================================================================
module dai_div_cell (
    input  logic          clk,
    input  dai_pkg::dv_t  din,
    output dai_pkg::dv_t  dout
);

    dai_pkg::dv_t dout_reg;
    dai_pkg::dv_t dout_next;
    logic                      ge;
    logic [dai_pkg::DV_W-1:0]  diff;

    always_comb
    begin
        ge   = (din.rem >= din.den);
        diff = ge ? (din.rem - din.den) : din.rem;
        dout_next.rem = {diff[dai_pkg::DV_W-2:0], 1'b0};
        dout_next.den = din.den;
        dout_next.q   = {din.q[dai_pkg::DV_Q_W-2:0], ge};
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[rtl/dai_cordic_cell.sv]
// ============================================================================
// dai_cordic_cell: one CORDIC vectoring rotation
// Rotate toward the x axis by the table angle of this step.
// ============================================================================
module dai_cordic_cell (
    input  logic                        clk,
    input  logic [dai_pkg::CR_I_W-1:0]  step_idx,
    input  dai_pkg::cr_t                din,
    output dai_pkg::cr_t                dout
);

    dai_pkg::cr_t dout_reg;
    dai_pkg::cr_t dout_next;
    logic signed [dai_pkg::CR_W-1:0]   xs;
    logic signed [dai_pkg::CR_W-1:0]   ys;
    logic signed [dai_pkg::CR_Z_W-1:0] da;

    always_comb
    begin
        xs = $signed(din.x) >>> step_idx;
        ys = $signed(din.y) >>> step_idx;
        da = $signed(dai_pkg::CR_Z_W'(dai_pkg::ATAN_TAB[step_idx]));
        if (!din.y[dai_pkg::CR_W-1])
        begin
            dout_next.x = $signed(din.x) + ys;
            dout_next.y = $signed(din.y) - xs;
            dout_next.z = $signed(din.z) + da;
        end
        else
        begin
            dout_next.x = $signed(din.x) - ys;
            dout_next.y = $signed(din.y) + xs;
            dout_next.z = $signed(din.z) - da;
        end
    end

    always_ff @(posedge clk)
    begin
        dout_reg <= dout_next;
    end

    assign dout = dout_reg;

endmodule

[rtl/dai_ratio_acos.sv]
// ============================================================================
// dai_ratio_acos: arc cosine of a signed ratio
// Divider chain forms the Q.16 cosine, a root chain its sine, and a CORDIC
// chain the angle, clamped to [0, pi].
// ============================================================================
module dai_ratio_acos (
    input  logic                         clk,
    input  dai_pkg::dv_t                 dv_in,
    input  logic                         neg,
    output logic [dai_pkg::ANG_W-1:0]    ang
);

    dai_pkg::dv_t dv [0:dai_pkg::DV_STEPS];
    dai_pkg::sq_t sq [0:dai_pkg::S_STEPS];
    dai_pkg::cr_t cr [0:dai_pkg::CR_STEPS];

    logic                           neg_dly_reg [dai_pkg::DV_STEPS];
    logic signed [dai_pkg::C_W-1:0] c_dly_reg   [dai_pkg::S_STEPS];

    logic signed [dai_pkg::C_W-1:0]     c7_reg, c7_next, c8_reg, c9_reg;
    logic signed [2*dai_pkg::C_W-1:0]   csq_reg, csq_next;
    logic [dai_pkg::SRAD_W-1:0]         srad_reg, srad_next;
    logic [dai_pkg::S_STEPS-1:0]        s_root;
    logic signed [dai_pkg::CR_W-1:0]    s_x, c_x;
    dai_pkg::cr_t                       cr_in_reg, cr_in_next;
    logic signed [dai_pkg::CR_Z_W-1:0]  z_fin;
    logic [dai_pkg::ANG_W-1:0]          ang_reg, ang_next;

    assign dv[0] = dv_in;

    for (genvar k = 0; k < dai_pkg::DV_STEPS; k++)
    begin : g_div
        dai_div_cell u_cell (.clk(clk), .din(dv[k]), .dout(dv[k+1]));
    end

    always_ff @(posedge clk)
    begin
        neg_dly_reg[0] <= neg;
        for (int k = 1; k < dai_pkg::DV_STEPS; k++)
        begin
            neg_dly_reg[k] <= neg_dly_reg[k-1];
        end
    end

    // apply the sign, then square and subtract from one for the sine
    always_comb
    begin
        c7_next = neg_dly_reg[dai_pkg::DV_STEPS-1] ?
                  -$signed({1'b0, dv[dai_pkg::DV_STEPS].q}) :
                  $signed({1'b0, dv[dai_pkg::DV_STEPS].q});
        csq_next  = c7_reg * c7_reg;
        srad_next = dai_pkg::ONE_SQ_Q32 - dai_pkg::SRAD_W'(csq_reg);
    end

    always_ff @(posedge clk)
    begin
        c7_reg   <= c7_next;
        csq_reg  <= csq_next;
        c8_reg   <= c7_reg;
        srad_reg <= srad_next;
        c9_reg   <= c8_reg;
    end

    // radicand left-aligned so the short chain yields the root of its top bits
    always_comb
    begin
        sq[0].rad  = dai_pkg::SQ_W'({1'b0, srad_reg}) << dai_pkg::SQ_PAD;
        sq[0].rem  = '0;
        sq[0].root = '0;
    end

    for (genvar k = 0; k < dai_pkg::S_STEPS; k++)
    begin : g_sqrt
        dai_sqrt_cell u_cell (.clk(clk), .din(sq[k]), .dout(sq[k+1]));
    end

    always_ff @(posedge clk)
    begin
        c_dly_reg[0] <= c9_reg;
        for (int k = 1; k < dai_pkg::S_STEPS; k++)
        begin
            c_dly_reg[k] <= c_dly_reg[k-1];
        end
    end

    // a vector left of the y axis starts turned by a quarter turn
    always_comb
    begin
        s_root = sq[dai_pkg::S_STEPS].root[dai_pkg::S_STEPS-1:0];
        s_x    = dai_pkg::CR_W'({1'b0, s_root, {dai_pkg::CR_PRE{1'b0}}});
        c_x    = dai_pkg::CR_W'(c_dly_reg[dai_pkg::S_STEPS-1]) <<< dai_pkg::CR_PRE;
        if (c_dly_reg[dai_pkg::S_STEPS-1][dai_pkg::C_W-1])
        begin
            cr_in_next.x = s_x;
            cr_in_next.y = -c_x;
            cr_in_next.z = dai_pkg::HALF_PI_Q16;
        end
        else
        begin
            cr_in_next.x = c_x;
            cr_in_next.y = s_x;
            cr_in_next.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        cr_in_reg <= cr_in_next;
    end

    assign cr[0] = cr_in_reg;

    for (genvar k = 0; k < dai_pkg::CR_STEPS; k++)
    begin : g_cordic
        dai_cordic_cell u_cell (
            .clk      (clk),
            .step_idx (dai_pkg::CR_I_W'(k)),
            .din      (cr[k]),
            .dout     (cr[k+1])
        );
    end

    always_comb
    begin
        z_fin = $signed(cr[dai_pkg::CR_STEPS].z);
        if (z_fin[dai_pkg::CR_Z_W-1])
        begin
            ang_next = '0;
        end
        else if (z_fin > dai_pkg::PI_Q16)
        begin
            ang_next = dai_pkg::ANG_W'(dai_pkg::PI_Q16);
        end
        else
        begin
            ang_next = dai_pkg::ANG_W'(z_fin);
        end
    end

    always_ff @(posedge clk)
    begin
        ang_reg <= ang_next;
    end

    assign ang = ang_reg;

endmodule

[rtl/dai_arm.sv]
// ============================================================================
// dai_arm: joint solution for one arm
// Project into the arm plane, take the distance, check reach, form both
// angles and scale their difference into motor steps.
// ============================================================================
module dai_arm (
    input  logic                                clk,
    input  logic [dai_pkg::ARM_IDX_W-1:0]       arm_idx,
    input  dai_pkg::dai_cfg_t                   cfg,
    input  logic signed [dai_pkg::POS_W-1:0]    pos_x,
    input  logic signed [dai_pkg::POS_W-1:0]    pos_y,
    input  logic signed [dai_pkg::POS_W-1:0]    pos_z,
    output logic signed [dai_pkg::STEP_W-1:0]   steps,
    output logic                                fail
);

    logic signed [dai_pkg::SUM_W-1:0]     prod_x, prod_y, sum_next, sum_reg;
    logic signed [dai_pkg::POS_W-1:0]     z1_reg, z2_reg;
    logic signed [dai_pkg::EX_W-1:0]      ex_next, ex_reg, ex3_reg, ex4_reg, ex5_reg;
    logic signed [2*dai_pkg::EX_W-1:0]    ex2_next, ex2_reg;
    logic signed [2*dai_pkg::POS_W-1:0]   zz_next, zz_reg;
    logic [dai_pkg::SQ_W-1:0]             d2_next, d2_reg;
    logic signed [dai_pkg::NUM_W-1:0]     num_next, num_reg, num5_reg;

    dai_pkg::sq_t sq_d [0:dai_pkg::D_STEPS];
    logic signed [dai_pkg::NUM_W-1:0]     num_dly_reg [dai_pkg::D_STEPS];
    logic signed [dai_pkg::EX_W-1:0]      ex_dly_reg  [dai_pkg::D_STEPS];

    logic [dai_pkg::SQ_ROOT_W-1:0]            d_w, d5_reg;
    logic [dai_pkg::LEN_W+dai_pkg::SQ_ROOT_W-1:0] l1d;
    logic [dai_pkg::DV_W-1:0]                 den_next, den5_reg;

    logic [dai_pkg::NUM_W-1:0]    num_mag;
    logic [dai_pkg::EX_W-1:0]     ex_mag;
    logic                         fail_next;
    dai_pkg::dv_t                 dva_next, dvb_next, dva_reg, dvb_reg;
    logic                         nega_reg, negb_reg;
    logic                         fail_dly_reg [dai_pkg::FAIL_DLY];

    logic [dai_pkg::ANG_W-1:0]                alpha, beta;
    logic signed [dai_pkg::ANG_W:0]           diff_next, diff_reg;
    logic [dai_pkg::ANG_W-1:0]                mag;
    logic [dai_pkg::ANG_W+dai_pkg::SPR_W-1:0] prod_next, prod_reg;
    logic                                     neg_reg;
    logic [dai_pkg::ANG_W+dai_pkg::SPR_W-dai_pkg::STEP_SHIFT-1:0] p;
    logic signed [dai_pkg::STEP_W-1:0]        steps_next, steps_reg;

    // plane projection, rounded half up, then radial offset
    assign prod_x   = pos_x * dai_pkg::ARM_COS[arm_idx];
    assign prod_y   = pos_y * dai_pkg::ARM_SIN[arm_idx];
    assign sum_next = prod_x + prod_y + dai_pkg::ROUND_Q16;
    assign ex_next  = dai_pkg::EX_W'(sum_reg >>> dai_pkg::FRAC_Q16)
                    - dai_pkg::EX_W'(cfg.off);
    assign ex2_next = ex_reg * ex_reg;
    assign zz_next  = z2_reg * z2_reg;
    assign d2_next  = dai_pkg::SQ_W'(ex2_reg) + dai_pkg::SQ_W'(zz_reg);
    assign num_next = dai_pkg::NUM_W'(cfg.lsqd) + dai_pkg::NUM_W'(ex2_reg)
                    + dai_pkg::NUM_W'(zz_reg);

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        z1_reg  <= pos_z;
        ex_reg  <= ex_next;
        z2_reg  <= z1_reg;
        ex2_reg <= ex2_next;
        zz_reg  <= zz_next;
        ex3_reg <= ex_reg;
        d2_reg  <= d2_next;
        num_reg <= num_next;
        ex4_reg <= ex3_reg;
    end

    always_comb
    begin
        sq_d[0].rad  = d2_reg;
        sq_d[0].rem  = '0;
        sq_d[0].root = '0;
    end

    for (genvar k = 0; k < dai_pkg::D_STEPS; k++)
    begin : g_dist
        dai_sqrt_cell u_cell (.clk(clk), .din(sq_d[k]), .dout(sq_d[k+1]));
    end

    always_ff @(posedge clk)
    begin
        num_dly_reg[0] <= num_reg;
        ex_dly_reg[0]  <= ex4_reg;
        for (int k = 1; k < dai_pkg::D_STEPS; k++)
        begin
            num_dly_reg[k] <= num_dly_reg[k-1];
            ex_dly_reg[k]  <= ex_dly_reg[k-1];
        end
    end

    assign d_w      = sq_d[dai_pkg::D_STEPS].root;
    assign l1d      = cfg.l1 * d_w;
    assign den_next = dai_pkg::DV_W'({l1d, 1'b0});

    always_ff @(posedge clk)
    begin
        d5_reg   <= d_w;
        den5_reg <= den_next;
        num5_reg <= num_dly_reg[dai_pkg::D_STEPS-1];
        ex5_reg  <= ex_dly_reg[dai_pkg::D_STEPS-1];
    end

    // reach checks: zero distance, zero upper arm, either ratio beyond one
    always_comb
    begin
        num_mag = num5_reg[dai_pkg::NUM_W-1] ? -num5_reg : num5_reg;
        ex_mag  = ex5_reg[dai_pkg::EX_W-1] ? -ex5_reg : ex5_reg;
        fail_next = (d5_reg == '0) || (den5_reg == '0)
                 || (num_mag > dai_pkg::NUM_W'(den5_reg))
                 || (ex_mag > dai_pkg::EX_W'(d5_reg));
        dva_next.rem = dai_pkg::DV_W'(num_mag);
        dva_next.den = den5_reg;
        dva_next.q   = '0;
        dvb_next.rem = dai_pkg::DV_W'(ex_mag);
        dvb_next.den = dai_pkg::DV_W'(d5_reg);
        dvb_next.q   = '0;
    end

    always_ff @(posedge clk)
    begin
        dva_reg  <= dva_next;
        dvb_reg  <= dvb_next;
        nega_reg <= num5_reg[dai_pkg::NUM_W-1];
        negb_reg <= ex5_reg[dai_pkg::EX_W-1];
        fail_dly_reg[0] <= fail_next;
        for (int k = 1; k < dai_pkg::FAIL_DLY; k++)
        begin
            fail_dly_reg[k] <= fail_dly_reg[k-1];
        end
    end

    dai_ratio_acos u_alpha (.clk(clk), .dv_in(dva_reg), .neg(nega_reg), .ang(alpha));
    dai_ratio_acos u_beta  (.clk(clk), .dv_in(dvb_reg), .neg(negb_reg), .ang(beta));

    always_comb
    begin
        diff_next = $signed({1'b0, beta}) - $signed({1'b0, alpha});
        mag       = dai_pkg::ANG_W'(diff_reg[dai_pkg::ANG_W] ? -diff_reg : diff_reg);
        prod_next = mag * cfg.spr;
        p         = prod_reg[dai_pkg::ANG_W+dai_pkg::SPR_W-1:dai_pkg::STEP_SHIFT];
        steps_next = neg_reg ? -dai_pkg::STEP_W'(p) : dai_pkg::STEP_W'(p);
    end

    always_ff @(posedge clk)
    begin
        diff_reg  <= diff_next;
        prod_reg  <= prod_next;
        neg_reg   <= diff_reg[dai_pkg::ANG_W];
        steps_reg <= steps_next;
    end

    assign steps = steps_reg;
    assign fail  = fail_dly_reg[dai_pkg::FAIL_DLY-1];

endmodule

[rtl/delta_arm_inverse_kinematics_unit.sv]
// ============================================================================
// delta_arm_inverse_kinematics_unit: three-arm joint solver, fixed point
// Throughput: one position per cycle; busy never rises, the datapath is a
// fixed-depth chain of cells set by the distance root (26 cells), divider
// (17), sine root (17) and CORDIC (16) chains.
// Reset clears the configuration registers and the in-flight valid line;
// results leave on a one-cycle done strobe, and the receiver cannot stall.
// ============================================================================
module delta_arm_inverse_kinematics_unit (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic signed [dai_pkg::POS_W-1:0]      pos_x,
    input  logic signed [dai_pkg::POS_W-1:0]      pos_y,
    input  logic signed [dai_pkg::POS_W-1:0]      pos_z,
    output logic                                  done,
    output logic signed [dai_pkg::STEP_W-1:0]     steps_arm0,
    output logic signed [dai_pkg::STEP_W-1:0]     steps_arm1,
    output logic signed [dai_pkg::STEP_W-1:0]     steps_arm2,
    output logic                                  reach_status,
    output logic [dai_pkg::ARM_IDX_W-1:0]         failing_arm,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [dai_pkg::CFG_IDX_W-1:0]         cfg_index,
    input  logic [dai_pkg::CFG_DATA_W-1:0]        cfg_data
);

    logic [dai_pkg::LEN_W-1:0] base_radius_reg, effector_radius_reg;
    logic [dai_pkg::LEN_W-1:0] upper_arm_length_reg, lower_arm_length_reg;
    logic [dai_pkg::SPR_W-1:0] steps_per_radian_reg;

    logic signed [dai_pkg::OFF_W-1:0] off_reg, off_next;
    logic signed [dai_pkg::LSQ_W-1:0] lsqd_reg, lsqd_next;
    logic [2*dai_pkg::LEN_W-1:0]      l1sq, l2sq;
    dai_pkg::dai_cfg_t                cfg;

    logic accept;
    logic vld_reg [dai_pkg::ARM_LAT];

    logic signed [dai_pkg::STEP_W-1:0] arm_steps [dai_pkg::ARM_COUNT];
    logic                              arm_fail  [dai_pkg::ARM_COUNT];

    logic                              done_reg;
    logic signed [dai_pkg::STEP_W-1:0] steps0_reg, steps1_reg, steps2_reg;
    logic signed [dai_pkg::STEP_W-1:0] steps0_next, steps1_next, steps2_next;
    logic                              status_reg, status_next;
    logic [dai_pkg::ARM_IDX_W-1:0]     failing_reg, failing_next;

    // The pipeline never stalls: take a beat on every start.
    assign busy      = 1'b0;
    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Configuration writes; an unknown index is dropped.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_radius_reg      <= '0;
            effector_radius_reg  <= '0;
            upper_arm_length_reg <= '0;
            lower_arm_length_reg <= '0;
            steps_per_radian_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                dai_pkg::REG_BASE_RADIUS:
                    base_radius_reg <= cfg_data[dai_pkg::LEN_W-1:0];
                dai_pkg::REG_EFFECTOR_RADIUS:
                    effector_radius_reg <= cfg_data[dai_pkg::LEN_W-1:0];
                dai_pkg::REG_UPPER_ARM_LENGTH:
                    upper_arm_length_reg <= cfg_data[dai_pkg::LEN_W-1:0];
                dai_pkg::REG_LOWER_ARM_LENGTH:
                    lower_arm_length_reg <= cfg_data[dai_pkg::LEN_W-1:0];
                dai_pkg::REG_STEPS_PER_RADIAN:
                    steps_per_radian_reg <= cfg_data;
                default:
                    ;
            endcase
        end
    end

    // Hold the radial offset and the L1^2 - L2^2 term in registers; they
    // settle in the cycle after a write, long before any item reaches them.
    always_comb
    begin
        l1sq      = upper_arm_length_reg * upper_arm_length_reg;
        l2sq      = lower_arm_length_reg * lower_arm_length_reg;
        lsqd_next = $signed({2'b00, l1sq}) - $signed({2'b00, l2sq});
        off_next  = $signed({1'b0, base_radius_reg}) - $signed({1'b0, effector_radius_reg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            off_reg  <= '0;
            lsqd_reg <= '0;
        end
        else
        begin
            off_reg  <= off_next;
            lsqd_reg <= lsqd_next;
        end
    end

    always_comb
    begin
        cfg.off  = off_reg;
        cfg.l1   = upper_arm_length_reg;
        cfg.lsqd = lsqd_reg;
        cfg.spr  = steps_per_radian_reg;
    end

    // Three arm lanes run side by side on the same position.
    for (genvar a = 0; a < dai_pkg::ARM_COUNT; a++)
    begin : g_arm
        dai_arm u_arm (
            .clk     (clk),
            .arm_idx (dai_pkg::ARM_IDX_W'(a)),
            .cfg     (cfg),
            .pos_x   (pos_x),
            .pos_y   (pos_y),
            .pos_z   (pos_z),
            .steps   (arm_steps[a]),
            .fail    (arm_fail[a])
        );
    end

    // Track each accepted beat down the fixed-depth lanes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < dai_pkg::ARM_LAT; k++)
            begin
                vld_reg[k] <= 1'b0;
            end
        end
        else
        begin
            vld_reg[0] <= accept;
            for (int k = 1; k < dai_pkg::ARM_LAT; k++)
            begin
                vld_reg[k] <= vld_reg[k-1];
            end
        end
    end

    // Report the lowest failing arm and zero all steps when out of reach.
    always_comb
    begin
        status_next  = 1'b0;
        failing_next = '0;
        for (int a = dai_pkg::ARM_COUNT - 1; a >= 0; a--)
        begin
            if (arm_fail[a])
            begin
                status_next  = 1'b1;
                failing_next = dai_pkg::ARM_IDX_W'(a);
            end
        end
        steps0_next = status_next ? '0 : arm_steps[0];
        steps1_next = status_next ? '0 : arm_steps[1];
        steps2_next = status_next ? '0 : arm_steps[2];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= vld_reg[dai_pkg::ARM_LAT-1];
        end
    end

    always_ff @(posedge clk)
    begin
        steps0_reg  <= steps0_next;
        steps1_reg  <= steps1_next;
        steps2_reg  <= steps2_next;
        status_reg  <= status_next;
        failing_reg <= failing_next;
    end

    assign done         = done_reg;
    assign steps_arm0   = steps0_reg;
    assign steps_arm1   = steps1_reg;
    assign steps_arm2   = steps2_reg;
    assign reach_status = status_reg;
    assign failing_arm  = failing_reg;

endmodule

[test/tb_delta_arm_inverse_kinematics_unit.sv]
`timescale 1ns / 100ps
// ============================================================================
// tb_delta_arm_inverse_kinematics_unit: self-checking bench for the joint solver
// Drives effector positions through the command port and walks a short table
// of directed positions. It then drives random phases that favor positions
// near the work envelope, each under its own register setting. Every done beat
// is checked field by field against its typed row or the fixed point solver.
// ============================================================================
module tb_delta_arm_inverse_kinematics_unit;

    localparam int  REG_COUNT    = 5;
    localparam int  DRAIN_CYCLES = 120;
    localparam int  CYCLE_LIMIT  = 400000;
    localparam int  RANDOM_ITEMS = 650;
    localparam int  PHASES       = 6;
    localparam int  MAX_REPORTS  = 10;
    localparam int  DIRECTED_ROWS = 21;
    localparam longint STEP_HI   = 1048575;
    localparam longint STEP_LO   = -1048576;
    localparam longint ANGLE_PI  = 205887;
    localparam longint ANGLE_HALF_PI = 102944;

    typedef struct {
        logic signed [dai_pkg::STEP_W-1:0] s0;
        logic signed [dai_pkg::STEP_W-1:0] s1;
        logic signed [dai_pkg::STEP_W-1:0] s2;
        logic                              unreachable;
        logic [dai_pkg::ARM_IDX_W-1:0]     arm;
    } joint_beat_t;

    typedef struct {
        bit     needs_cfg;   // apply the nominal geometry before this row
        int     x;
        int     y;
        int     z;
        bit     typed;       // expected beat is given in the row
        bit     unreachable;
        int     arm;
    } stim_row_t;

    logic                                clk;
    logic                                rst_n;
    logic                                start;
    logic                                busy;
    logic signed [dai_pkg::POS_W-1:0]    pos_x;
    logic signed [dai_pkg::POS_W-1:0]    pos_y;
    logic signed [dai_pkg::POS_W-1:0]    pos_z;
    logic                                done;
    logic signed [dai_pkg::STEP_W-1:0]   steps_arm0;
    logic signed [dai_pkg::STEP_W-1:0]   steps_arm1;
    logic signed [dai_pkg::STEP_W-1:0]   steps_arm2;
    logic                                reach_status;
    logic [dai_pkg::ARM_IDX_W-1:0]       failing_arm;
    logic                                cfg_valid;
    logic                                cfg_ready;
    logic [dai_pkg::CFG_IDX_W-1:0]       cfg_index;
    logic [dai_pkg::CFG_DATA_W-1:0]      cfg_data;

    // bench copy of the geometry registers
    longint unsigned geo_base;
    longint unsigned geo_eff;
    longint unsigned geo_l1;
    longint unsigned geo_l2;
    longint unsigned geo_spr;

    joint_beat_t pending_joints[$];
    int          mismatches;
    bit          no_gaps;

    delta_arm_inverse_kinematics_unit dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .done         (done),
        .steps_arm0   (steps_arm0),
        .steps_arm1   (steps_arm1),
        .steps_arm2   (steps_arm2),
        .reach_status (reach_status),
        .failing_arm  (failing_arm),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Fixed point solver
    // ------------------------------------------------------------------------
    function automatic longint shr_floor(longint v, int s);
        if (v >= 0)
            return v >>> s;
        return -(((-v) - 1) >>> s) - 1;
    endfunction

    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > v)
            bitv = bitv >> 2;
        while (bitv != 0)
        begin
            if (v >= res + bitv)
            begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
                res = res >> 1;
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    // arccosine of a Q.16 cosine by CORDIC vectoring, Q3.16 result
    function automatic longint arccos_q16(longint c);
        longint s;
        longint cx;
        longint cy;
        longint cz;
        longint xs;
        longint ys;
        s = longint'(root_floor(64'd4294967296 - longint'(c * c)));
        if (c < 0)
        begin
            cx = s * 256;
            cy = -c * 256;
            cz = ANGLE_HALF_PI;
        end
        else
        begin
            cx = c * 256;
            cy = s * 256;
            cz = 0;
        end
        for (int i = 0; i < dai_pkg::CR_STEPS; i++)
        begin
            xs = shr_floor(cx, i);
            ys = shr_floor(cy, i);
            if (cy >= 0)
            begin
                cx = cx + ys;
                cy = cy - xs;
                cz = cz + longint'(dai_pkg::ATAN_TAB[i]);
            end
            else
            begin
                cx = cx - ys;
                cy = cy + xs;
                cz = cz - longint'(dai_pkg::ATAN_TAB[i]);
            end
        end
        if (cz < 0)
            cz = 0;
        if (cz > ANGLE_PI)
            cz = ANGLE_PI;
        return cz;
    endfunction

    function automatic longint ratio_q16(longint num, longint den);
        longint unsigned mag;
        longint unsigned q;
        mag = (num < 0) ? longint'(-num) : longint'(num);
        q   = (mag << 16) / longint'(den);
        return (num < 0) ? -longint'(q) : longint'(q);
    endfunction

    function automatic bit arm_joint_angle(longint x, longint y, longint z, int arm,
                                           output longint ang);
        longint xp;
        longint ex;
        longint d2;
        longint d;
        longint l1;
        longint l2;
        longint num;
        longint den;
        ang = 0;
        xp  = shr_floor(x * longint'(dai_pkg::ARM_COS[arm])
                        + y * longint'(dai_pkg::ARM_SIN[arm]) + 32768, 16);
        ex  = xp - (longint'(geo_base) - longint'(geo_eff));
        d2  = ex * ex + z * z;
        d   = longint'(root_floor(d2));
        l1  = longint'(geo_l1);
        l2  = longint'(geo_l2);
        if (d == 0)
            return 0;
        num = l1 * l1 + d2 - l2 * l2;
        den = 2 * l1 * d;
        if (den == 0)
            return 0;
        if (num > den || -num > den)
            return 0;
        if (ex > d || -ex > d)
            return 0;
        ang = arccos_q16(ratio_q16(ex, d)) - arccos_q16(ratio_q16(num, den));
        return 1;
    endfunction

    function automatic longint motor_step_count(longint ang);
        longint unsigned mag;
        longint unsigned p;
        longint r;
        mag = (ang < 0) ? longint'(-ang) : longint'(ang);
        p   = (mag * geo_spr) >> dai_pkg::STEP_SHIFT;
        if (p > longint'(STEP_HI) + 1)
            p = longint'(STEP_HI) + 1;
        r = (ang < 0) ? -longint'(p) : longint'(p);
        if (r > STEP_HI)
            r = STEP_HI;
        if (r < STEP_LO)
            r = STEP_LO;
        return r;
    endfunction

    function automatic joint_beat_t solve_joints(longint x, longint y, longint z);
        joint_beat_t jb;
        longint      ang;
        longint      st[dai_pkg::ARM_COUNT];
        jb = '{default: '0};
        for (int i = 0; i < dai_pkg::ARM_COUNT; i++)
        begin
            if (!arm_joint_angle(x, y, z, i, ang))
            begin
                jb.unreachable = 1'b1;
                jb.arm         = dai_pkg::ARM_IDX_W'(i);
                return jb;
            end
            st[i] = motor_step_count(ang);
        end
        jb.s0 = dai_pkg::STEP_W'(st[0]);
        jb.s1 = dai_pkg::STEP_W'(st[1]);
        jb.s2 = dai_pkg::STEP_W'(st[2]);
        return jb;
    endfunction

    // ------------------------------------------------------------------------
    // Clock and the run limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run; the limit is many times the slowest correct run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result checker: every done beat pops the oldest expectation
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        joint_beat_t want;
        if (rst_n && done)
        begin
            if (pending_joints.size() == 0)
            begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected done beat: steps %0d %0d %0d status %0d arm %0d",
                             steps_arm0, steps_arm1, steps_arm2, reach_status, failing_arm);
            end
            else
            begin
                want = pending_joints.pop_front();
                if (steps_arm0 !== want.s0 || steps_arm1 !== want.s1 ||
                    steps_arm2 !== want.s2 || reach_status !== want.unreachable ||
                    failing_arm !== want.arm)
                begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTS)
                        $display({"mismatch: exp steps %0d %0d %0d st %0d arm %0d,",
                                  " got %0d %0d %0d st %0d arm %0d"},
                                 want.s0, want.s1, want.s2, want.unreachable, want.arm,
                                 steps_arm0, steps_arm1, steps_arm2, reach_status,
                                 failing_arm);
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Drivers: inputs move on the falling edge only
    // ------------------------------------------------------------------------

    // Issue one position beat after a gap; hold start until the unit takes it.
    task automatic send_position(int x, int y, int z, int gap, bit typed,
                                 joint_beat_t typed_beat);
        repeat (gap)
        begin
            @(negedge clk);
            start <= 1'b0;
        end
        @(negedge clk);
        start <= 1'b1;
        pos_x <= dai_pkg::POS_W'(x);
        pos_y <= dai_pkg::POS_W'(y);
        pos_z <= dai_pkg::POS_W'(z);
        do
            @(posedge clk);
        while (busy);
        if (typed)
            pending_joints.push_back(typed_beat);
        else
            pending_joints.push_back(solve_joints(longint'($signed(dai_pkg::POS_W'(x))),
                                                  longint'($signed(dai_pkg::POS_W'(y))),
                                                  longint'($signed(dai_pkg::POS_W'(z)))));
    endtask

    // Drop start, wait out every beat in flight plus the pipeline depth.
    task automatic drain_unit();
        @(negedge clk);
        start <= 1'b0;
        while (pending_joints.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(int idx, logic [dai_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= dai_pkg::CFG_IDX_W'(idx);
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        case (idx)
            dai_pkg::REG_BASE_RADIUS:      geo_base = val & 24'hFFFFF;
            dai_pkg::REG_EFFECTOR_RADIUS:  geo_eff  = val & 24'hFFFFF;
            dai_pkg::REG_UPPER_ARM_LENGTH: geo_l1   = val & 24'hFFFFF;
            dai_pkg::REG_LOWER_ARM_LENGTH: geo_l2   = val & 24'hFFFFF;
            dai_pkg::REG_STEPS_PER_RADIAN: geo_spr  = val;
            default: ;
        endcase
    endtask

    task automatic write_geometry(int b, int e, int l1, int l2, int spr);
        write_register(dai_pkg::REG_BASE_RADIUS, dai_pkg::CFG_DATA_W'(b));
        write_register(dai_pkg::REG_EFFECTOR_RADIUS, dai_pkg::CFG_DATA_W'(e));
        write_register(dai_pkg::REG_UPPER_ARM_LENGTH, dai_pkg::CFG_DATA_W'(l1));
        write_register(dai_pkg::REG_LOWER_ARM_LENGTH, dai_pkg::CFG_DATA_W'(l2));
        write_register(dai_pkg::REG_STEPS_PER_RADIAN, dai_pkg::CFG_DATA_W'(spr));
    endtask

    // ------------------------------------------------------------------------
    // Directed table
    // Nominal geometry (Q.8 mm): base 100, effector 30, arms 150 and 300.
    // ------------------------------------------------------------------------
    localparam int NOM_BASE = 25600;
    localparam int NOM_EFF  = 7680;
    localparam int NOM_L1   = 38400;
    localparam int NOM_L2   = 76800;
    localparam int NOM_SPR  = 2084864;
    localparam int POS_MAX  = 8388607;
    localparam int POS_MIN  = -8388608;

    stim_row_t directed_rows [DIRECTED_ROWS] = '{
        // registers at reset: zero upper arm or zero distance fails arm 0
        '{0, 0, 0, 0, 1, 1, 0},
        '{0, POS_MAX, POS_MAX, POS_MAX, 1, 1, 0},
        '{0, POS_MIN, POS_MIN, POS_MIN, 1, 1, 0},
        '{0, 25600, -25600, -64000, 1, 1, 0},
        // nominal geometry from here on
        '{1, 0, 0, -64000, 0, 0, 0},
        '{1, 12800, 7680, -71680, 0, 0, 0},
        '{1, -15360, 10240, -58880, 0, 0, 0},
        '{1, 0, -20480, -87040, 0, 0, 0},
        '{1, 30000, -30000, -60000, 0, 0, 0},
        // zero distance on arm 0: projected point lands on the joint
        '{1, 17920, 0, 0, 1, 1, 0},
        // far below the envelope: cosine out of range on arm 0
        '{1, 0, 0, -512000, 1, 1, 0},
        '{1, 0, 0, 0, 0, 0, 0},
        '{1, POS_MAX, 0, 0, 0, 0, 0},
        '{1, POS_MIN, 0, 0, 0, 0, 0},
        '{1, 0, POS_MAX, 0, 0, 0, 0},
        '{1, 0, POS_MIN, 0, 0, 0, 0},
        '{1, 0, 0, POS_MAX, 0, 0, 0},
        '{1, 0, 0, POS_MIN, 0, 0, 0},
        '{1, 0, 60000, -70000, 0, 0, 0},
        '{1, -40000, -40000, -70000, 0, 0, 0},
        '{1, 0, 0, -30000, 0, 0, 0}
    };

    // ------------------------------------------------------------------------
    // Stimulus sequence
    // ------------------------------------------------------------------------
    initial
    begin
        joint_beat_t tb;
        bit          cfg_done;
        int          b, e, l1, l2, spr, reach, x, y, z, gap;

        rst_n      = 1'b0;
        start      = 1'b0;
        pos_x      = '0;
        pos_y      = '0;
        pos_z      = '0;
        cfg_valid  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        mismatches = 0;
        no_gaps    = 0;
        geo_base   = 0;
        geo_eff    = 0;
        geo_l1     = 0;
        geo_l2     = 0;
        geo_spr    = 0;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Walk the directed table; load the nominal geometry once.
        cfg_done = 0;
        foreach (directed_rows[i])
        begin
            if (directed_rows[i].needs_cfg && !cfg_done)
            begin
                drain_unit();
                write_geometry(NOM_BASE, NOM_EFF, NOM_L1, NOM_L2, NOM_SPR);
                cfg_done = 1;
            end
            tb = '{default: '0};
            tb.unreachable = directed_rows[i].unreachable;
            tb.arm         = dai_pkg::ARM_IDX_W'(directed_rows[i].arm);
            send_position(directed_rows[i].x, directed_rows[i].y, directed_rows[i].z,
                          $urandom_range(0, 2), directed_rows[i].typed, tb);
        end

        // Random phases, each under a fresh register setting.
        for (int p = 0; p < PHASES; p++)
        begin
            drain_unit();
            case (p)
                2:
                begin
                    // every register at its ceiling
                    b = 20'hFFFFF; e = 20'hFFFFF; l1 = 20'hFFFFF; l2 = 20'hFFFFF;
                    spr = 24'hFFFFFF;
                end
                3:
                begin
                    // effector wider than base: negative joint offset
                    b = $urandom_range(5120, 15360); e = $urandom_range(20480, 40960);
                    l1 = $urandom_range(25600, 64000); l2 = $urandom_range(51200, 128000);
                    spr = $urandom_range(0, 24'hFFFFFF);
                end
                default:
                begin
                    b = $urandom_range(12800, 51200); e = $urandom_range(5120, 15360);
                    l1 = $urandom_range(25600, 64000); l2 = $urandom_range(51200, 128000);
                    spr = $urandom_range(1024, 8388608);
                end
            endcase
            write_geometry(b, e, l1, l2, spr);
            // poke an unused index; it must leave the geometry untouched
            write_register($urandom_range(REG_COUNT, 7), dai_pkg::CFG_DATA_W'($urandom));
            if (p == 5)
            begin
                // upper data bits beyond the 20 bit registers are dropped
                write_register(dai_pkg::REG_UPPER_ARM_LENGTH,
                               dai_pkg::CFG_DATA_W'(l1 | 24'hF00000));
                write_register(dai_pkg::REG_STEPS_PER_RADIAN,
                               dai_pkg::CFG_DATA_W'($urandom));
            end
            no_gaps = (p == 1 || p == 4);
            reach   = l1 + l2;
            for (int k = 0; k < RANDOM_ITEMS / PHASES; k++)
            begin
                if ($urandom_range(0, 99) < 15)
                begin
                    // noise across the full coordinate range
                    x = int'($signed(dai_pkg::POS_W'($urandom)));
                    y = int'($signed(dai_pkg::POS_W'($urandom)));
                    z = int'($signed(dai_pkg::POS_W'($urandom)));
                end
                else
                begin
                    // inside or near the envelope under the base
                    x = $signed($urandom_range(0, reach)) - reach / 2;
                    y = $signed($urandom_range(0, reach)) - reach / 2;
                    z = -$signed($urandom_range(reach / 5, reach));
                end
                gap = no_gaps ? 0 : $urandom_range(0, 12);
                send_position(x, y, z, gap, 0, tb);
            end
        end

        drain_unit();
        if (mismatches == 0 && pending_joints.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

[delta_arm_inverse_kinematics_unit.f]
rtl/dai_pkg.sv
rtl/dai_sqrt_cell.sv
rtl/dai_div_cell.sv
rtl/dai_cordic_cell.sv
rtl/dai_ratio_acos.sv
rtl/dai_arm.sv
rtl/delta_arm_inverse_kinematics_unit.sv
test/tb_delta_arm_inverse_kinematics_unit.sv
